// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the bus decoder modules. Each macro samples on
// the rising edge of clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge.
`define AMD_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// When pre holds, post holds at the next clock edge.
`define AMD_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`else

`define AMD_ASSERT_ALWAYS(lbl, cond)
`define AMD_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

// ===== rtl/core/amd_pkg.sv =====
// ----------------------------------------------------------------------------
// amd_pkg
// Types, sizes and codes shared by the bus decoder front, queue and back.
// ----------------------------------------------------------------------------
package amd_pkg;

  // Storage sizes.
  localparam int MEM_BYTES = 65536;
  localparam int MEM_AW    = $clog2(MEM_BYTES);
  localparam int BRK_DEPTH = 65536;
  localparam int BRK_AW    = $clog2(BRK_DEPTH);
  localparam int RX_DEPTH  = 256;
  localparam int RX_PW     = $clog2(RX_DEPTH);
  localparam int RX_CW     = $clog2(RX_DEPTH + 1);
  localparam int Q_DEPTH   = 2;
  localparam int Q_AW      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW      = $clog2(Q_DEPTH + 1);

  // Serial port addresses.
  localparam logic [15:0] PORT_STATUS = 16'hF000;
  localparam logic [15:0] PORT_DATA   = 16'hF001;
  localparam logic [15:0] PORT_STRAP  = 16'hF002;

  // Status register values.
  localparam logic [7:0] ST_RX_READY = 8'h03;
  localparam logic [7:0] ST_RX_EMPTY = 8'h02;

  // Receive character translation.
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] RAM_FILL = 8'hFF;

  // Command codes.
  localparam logic [2:0] CMD_READ    = 3'd0;
  localparam logic [2:0] CMD_WRITE   = 3'd1;
  localparam logic [2:0] CMD_PUSH    = 3'd2;
  localparam logic [2:0] CMD_SET_BRK = 3'd3;
  localparam logic [2:0] CMD_CLR_BRK = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_RAM_LOW  = 1'b0;
  localparam logic CFG_RAM_HIGH = 1'b1;

  // Classified operation carried from front to back.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_RD_STATUS,
    OP_RD_DATA,
    OP_RD_STRAP,
    OP_RD_RAM,
    OP_RD_ERR,
    OP_WR_TX,
    OP_WR_IGN,
    OP_WR_RAM,
    OP_WR_ERR,
    OP_PUSH,
    OP_SET_BRK,
    OP_CLR_BRK
  } op_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] address;
    logic [7:0]  data_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        tx_valid;
    logic [6:0]  tx_byte;
    logic        break_hit;
    logic [15:0] last_break_address;
    logic        bus_error;
    logic        rx_dropped;
  } out_item_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] address;
    logic [7:0]  data;
  } q_entry_t;

  // Head of the queue as the back sees it.
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  // Status from the back to the front.
  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

// ===== rtl/core/amd_front.sv =====
// ----------------------------------------------------------------------------
// amd_front
// Holds the RAM window registers and classifies each accepted bus beat into
// an operation for the back.
// ----------------------------------------------------------------------------
module amd_front
  import amd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [15:0] cfg_data,
  input  logic       in_push,
  output logic       in_full,
  input  in_item_t   in_item,
  input  logic       q_full,
  input  back_stat_t back_stat,
  output logic       q_push,
  output q_entry_t   q_entry
);

  logic [15:0] ram_low_r,  ram_low_nxt;
  logic [15:0] ram_high_r, ram_high_nxt;
  logic        in_ram;
  logic        is_port;

  always_comb begin
    ram_low_nxt  = ram_low_r;
    ram_high_nxt = ram_high_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_RAM_LOW:  ram_low_nxt  = cfg_data;
        CFG_RAM_HIGH: ram_high_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_low_r  <= 16'h0000;
      ram_high_r <= 16'hFFFF;
    end else begin
      ram_low_r  <= ram_low_nxt;
      ram_high_r <= ram_high_nxt;
    end
  end

  assign in_ram = (in_item.address >= ram_low_r) && (in_item.address <= ram_high_r) &&
                  ({1'b0, in_item.address} < 17'(MEM_BYTES));
  assign is_port = (in_item.address == PORT_STATUS) || (in_item.address == PORT_STRAP);

  assign in_full = q_full || back_stat.clearing;
  assign q_push  = in_push && !in_full;

  always_comb begin
    q_entry.address = in_item.address;
    q_entry.data    = in_item.data_in;
    unique case (in_item.cmd)
      CMD_READ: begin
        if (in_item.address == PORT_STATUS)     q_entry.op = OP_RD_STATUS;
        else if (in_item.address == PORT_DATA)  q_entry.op = OP_RD_DATA;
        else if (in_item.address == PORT_STRAP) q_entry.op = OP_RD_STRAP;
        else if (in_ram)                        q_entry.op = OP_RD_RAM;
        else                                    q_entry.op = OP_RD_ERR;
      end
      CMD_WRITE: begin
        if (in_item.address == PORT_DATA) q_entry.op = OP_WR_TX;
        else if (is_port)                 q_entry.op = OP_WR_IGN;
        else if (in_ram)                  q_entry.op = OP_WR_RAM;
        else                              q_entry.op = OP_WR_ERR;
      end
      CMD_PUSH:    q_entry.op = OP_PUSH;
      CMD_SET_BRK: q_entry.op = OP_SET_BRK;
      CMD_CLR_BRK: q_entry.op = OP_CLR_BRK;
      default:     q_entry.op = OP_NOP;
    endcase
  end

endmodule

// ===== rtl/core/amd_queue.sv =====
// ----------------------------------------------------------------------------
// amd_queue
// Short queue of classified operations between the front and the back.
// ----------------------------------------------------------------------------
module amd_queue
  import amd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t entry,
  output logic     full,
  input  logic     pop,
  output q_head_t  head
);

  `include "assert_macros.svh"

  q_entry_t            slot_r [Q_DEPTH];
  logic [Q_AW-1:0]     wp_r, wp_nxt;
  logic [Q_AW-1:0]     rp_r, rp_nxt;
  logic [Q_CW-1:0]     cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full     = (cnt_r == Q_CW'(Q_DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && (cnt_r != '0);

  assign head.valid = (cnt_r != '0);
  assign head.entry = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= entry;
    end
  end

  // Occupancy stays within the queue depth.
  `AMD_ASSERT_ALWAYS(a_q_cnt_bound, cnt_r <= Q_CW'(Q_DEPTH))
  // A push into a full queue that is not popped leaves it full.
  `AMD_ASSERT_NEXT(a_q_stay_full, full && !pop, full)

endmodule

// ===== rtl/core/amd_back.sv =====
// ----------------------------------------------------------------------------
// amd_back
// Carries out classified operations against the RAM, the break marks and
// the receive FIFO, and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module amd_back
  import amd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  q_head_t    head,
  output logic       q_pop,
  output back_stat_t back_stat,
  output logic       out_empty,
  input  logic       out_pop,
  output out_item_t  out_item
);

  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_ISSUE = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]  mem   [MEM_BYTES];
  logic        marks [BRK_DEPTH];
  logic [7:0]  fifo  [RX_DEPTH];

  logic [7:0]  mem_rd_r;
  logic        mark_rd_r;
  logic [7:0]  fifo_rd_r;

  logic [BRK_AW-1:0] clr_r, clr_nxt;
  q_entry_t          cur_r;

  logic [RX_PW-1:0]  rp_r, rp_nxt;
  logic [RX_CW-1:0]  cnt_r, cnt_nxt;
  logic [7:0]        last_r, last_nxt;
  logic [15:0]       brk_r, brk_nxt;

  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic              issue_go, exec_go;
  logic              mem_we;
  logic [MEM_AW-1:0] mem_wa;
  logic [7:0]        mem_wd;
  logic              mark_we;
  logic [BRK_AW-1:0] mark_wa;
  logic              mark_wd;
  logic              fifo_we;
  logic [RX_PW:0]    wsum;
  logic [RX_PW-1:0]  fifo_wa;
  logic              is_access;
  logic              rx_any;
  logic [7:0]        rx_byte;

  function automatic logic [7:0] translate_rx(input logic [7:0] c);
    if (c == CH_DEL)     return CH_BS;
    else if (c == CH_LF) return CH_CR;
    else                 return c;
  endfunction

  assign issue_go = (state_r == S_ISSUE) && head.valid && (!out_valid_r || out_pop);
  assign exec_go  = (state_r == S_EXEC);
  assign q_pop    = issue_go;

  assign back_stat.clearing = (state_r == S_CLEAR);
  assign out_empty = !out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == BRK_AW'(BRK_DEPTH - 1)) state_nxt = S_ISSUE;
      end
      S_ISSUE: if (issue_go) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_ISSUE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  assign is_access = (cur_r.op == OP_RD_STATUS) || (cur_r.op == OP_RD_DATA) ||
                     (cur_r.op == OP_RD_STRAP)  || (cur_r.op == OP_RD_RAM)  ||
                     (cur_r.op == OP_RD_ERR)    || (cur_r.op == OP_WR_TX)   ||
                     (cur_r.op == OP_WR_IGN)    || (cur_r.op == OP_WR_RAM)  ||
                     (cur_r.op == OP_WR_ERR);
  assign rx_any  = (cnt_r != '0);
  assign rx_byte = rx_any ? fifo_rd_r : last_r;

  assign wsum    = {1'b0, rp_r} + (RX_PW + 1)'(cnt_r);
  assign fifo_wa = (wsum >= (RX_PW + 1)'(RX_DEPTH)) ?
                   RX_PW'(wsum - (RX_PW + 1)'(RX_DEPTH)) : wsum[RX_PW-1:0];

  always_comb begin
    rp_nxt        = rp_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    brk_nxt       = brk_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    mem_wa        = cur_r.address[MEM_AW-1:0];
    mem_wd        = cur_r.data;
    mark_we       = 1'b0;
    mark_wa       = cur_r.address[BRK_AW-1:0];
    mark_wd       = 1'b0;
    fifo_we       = 1'b0;

    if (out_pop && out_valid_r) out_valid_nxt = 1'b0;

    if (state_r == S_CLEAR) begin
      mem_we  = ({1'b0, clr_r} < (BRK_AW + 1)'(MEM_BYTES));
      mem_wa  = clr_r[MEM_AW-1:0];
      mem_wd  = RAM_FILL;
      mark_we = 1'b1;
      mark_wa = clr_r;
    end

    if (exec_go) begin
      out_nxt = '0;
      if (is_access && mark_rd_r) begin
        out_nxt.break_hit = 1'b1;
        brk_nxt = cur_r.address;
      end
      case (cur_r.op)
        OP_RD_STATUS: out_nxt.read_data = rx_any ? ST_RX_READY : ST_RX_EMPTY;
        OP_RD_DATA: begin
          if (rx_any) begin
            last_nxt = fifo_rd_r;
            rp_nxt   = (rp_r == RX_PW'(RX_DEPTH - 1)) ? '0 : rp_r + 1'b1;
            cnt_nxt  = cnt_r - 1'b1;
          end
          out_nxt.read_data = translate_rx(rx_byte);
        end
        OP_RD_RAM: out_nxt.read_data = mem_rd_r;
        OP_RD_ERR, OP_WR_ERR: out_nxt.bus_error = 1'b1;
        OP_WR_TX: begin
          out_nxt.tx_valid = 1'b1;
          out_nxt.tx_byte  = cur_r.data[6:0];
        end
        OP_WR_RAM: mem_we = 1'b1;
        OP_PUSH: begin
          if (cnt_r == RX_CW'(RX_DEPTH)) begin
            out_nxt.rx_dropped = 1'b1;
          end else begin
            fifo_we = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        OP_SET_BRK: begin
          mark_we = 1'b1;
          mark_wd = 1'b1;
        end
        OP_CLR_BRK: mark_we = 1'b1;
        default: ;
      endcase
      out_nxt.last_break_address = brk_nxt;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      rp_r        <= '0;
      cnt_r       <= '0;
      last_r      <= 8'h00;
      brk_r       <= 16'h0000;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      rp_r        <= rp_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      brk_r       <= brk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (issue_go) cur_r <= head.entry;
  end

  // Synchronous RAMs: one write port, registered read at queue head or rp_r.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd_r <= mem[head.entry.address[MEM_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (mark_we) marks[mark_wa] <= mark_wd;
    mark_rd_r <= marks[head.entry.address[BRK_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (fifo_we) fifo[fifo_wa] <= cur_r.data;
    fifo_rd_r <= fifo[rp_r];
  end

  // The result slot is always free when an operation executes.
  `AMD_ASSERT_ALWAYS(a_exec_slot_free, (state_r != S_EXEC) || !out_valid_r)
  // The receive count never passes the FIFO depth.
  `AMD_ASSERT_ALWAYS(a_rx_cnt_bound, cnt_r <= RX_CW'(RX_DEPTH))
  // Executing an operation always leaves a result beat waiting.
  `AMD_ASSERT_NEXT(a_exec_result, state_r == S_EXEC, out_valid_r && (state_r == S_ISSUE))

endmodule

// ===== rtl/core/acia_memory_bus_decoder.sv =====
// A beat accepted into an empty block passes the queue, the back's read pass
// over the synchronous RAM, break mark and receive FIFO ports, its execute
// pass and the result register. The back finishes each beat before the next.
// Reset: a sweep loads every RAM byte with 0xFF and clears all break marks;
// in_full stays high during it while configuration writes are taken.
// ----------------------------------------------------------------------------
// acia_memory_bus_decoder
// Byte bus of an emulated 6800 machine: RAM window, break marks and a serial
// port with a receive FIFO, built as a classifying front and an executing back.
// ----------------------------------------------------------------------------
module acia_memory_bus_decoder
  import amd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // Input beats.
  input  logic        in_push,
  output logic        in_full,
  input  in_item_t    in_item,
  // Result beats.
  output logic        out_empty,
  input  logic        out_pop,
  output out_item_t   out_item
);

  // The front decodes the command and address into one operation code, so
  // the back never compares addresses. Port addresses win over the RAM window,
  // and the window test uses the configuration registers that the front holds.
  // The user must change configuration only while the block is idle; the block
  // does not enforce it, so an operation classified early sees the right window.
  logic       q_push;
  q_entry_t   q_entry;
  logic       q_full;
  logic       q_pop;
  q_head_t    q_head;
  back_stat_t back_stat;

  amd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .q_full    (q_full),
    .back_stat (back_stat),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  // A short queue lets the front keep taking beats while the back is busy
  // or waits on a result beat that has not been taken yet.
  amd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .entry (q_entry),
    .full  (q_full),
    .pop   (q_pop),
    .head  (q_head)
  );

  // The back reads RAM, break mark and FIFO head in its issue state and
  // executes on the registered data in the next cycle. Operations are carried
  // out one at a time, so each read sees every earlier write without bypassing.
  amd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_pop     (q_pop),
    .back_stat (back_stat),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
